@@ sv/hdlc_frame_wire_queue_defines.svh @@
// Assertion macros shared by the frame wire queue RTL.
// Depends on nothing; included by the top level, which writes its checks with these.
`ifndef HDLC_FRAME_WIRE_QUEUE_DEFINES_SVH
`define HDLC_FRAME_WIRE_QUEUE_DEFINES_SVH

// The condition must never hold outside reset.
`define HFWQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HFWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hfwq_pkg.sv @@
// Shared types and codes for the frame wire queue.
// Depends on nothing; used by every module of the block.
package hfwq_pkg;

    // One queue entry: byte plus address and end-of-frame marks.
    typedef struct packed {
        logic       end_mark;
        logic       addr_mark;
        logic [7:0] data;
    } hfwq_entry_t;

    typedef enum logic [2:0] {
        CMD_SEND    = 3'd0,
        CMD_EOF     = 3'd1,
        CMD_RECEIVE = 3'd2,
        CMD_PEEK    = 3'd3,
        CMD_DISCARD = 3'd4,
        CMD_RESEND  = 3'd5
    } hfwq_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DISC
    } hfwq_state_t;

    // Control from the sequencer to the hold-back buffer.
    typedef struct packed {
        logic push;
        logic clear;
    } hfwq_hold_ctrl_t;

endpackage

@@ sv/hfwq_ring.sv @@
// Ring storage of the frame wire queue: one write port, one registered read port.
// Depends on hfwq_pkg for the entry type.
module hfwq_ring
    import hfwq_pkg::*;
#(
    parameter int RING_DEPTH = 256,
    localparam int PTR_W = $clog2(RING_DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [PTR_W-1:0]  wr_addr,
    input  hfwq_entry_t       wr_entry,
    input  logic [PTR_W-1:0]  rd_addr,
    output hfwq_entry_t       rd_entry
);

    hfwq_entry_t mem [RING_DEPTH];
    hfwq_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

@@ sv/hfwq_hold.sv @@
// Hold-back buffer: keeps the newest sent bytes until the frame end is known.
// Depends on hfwq_pkg for the entry and control types.
module hfwq_hold
    import hfwq_pkg::*;
#(
    parameter int HOLD_DEPTH = 3,
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1),
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hfwq_hold_ctrl_t   ctrl,
    input  logic [7:0]        push_byte,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [CNT_W-1:0]  count,
    output logic              full,
    output hfwq_entry_t       head,
    output hfwq_entry_t       rd_entry
);

    hfwq_entry_t          hold_reg  [HOLD_DEPTH];
    hfwq_entry_t          hold_next [HOLD_DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    hfwq_entry_t          new_entry;

    always_comb
    begin
        // Only a byte that opens an empty buffer starts a frame.
        new_entry.end_mark  = 1'b0;
        new_entry.addr_mark = (count_reg == '0);
        new_entry.data      = push_byte;

        hold_next  = hold_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            if (!full)
            begin
                hold_next[count_reg[IDX_W-1:0]] = new_entry;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                // The oldest entry leaves for the ring; the rest move down.
                for (int i = 0; i < HOLD_DEPTH - 1; i++)
                begin
                    hold_next[i] = hold_reg[i + 1];
                end
                hold_next[HOLD_DEPTH - 1] = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign full     = (count_reg == CNT_W'(HOLD_DEPTH));
    assign count    = count_reg;
    assign head     = hold_reg[0];
    assign rd_entry = hold_reg[rd_idx];

endmodule

@@ sv/hdlc_frame_wire_queue.sv @@
// Top level of the frame wire queue: command sequencer, pointers and result register.
// Depends on hfwq_pkg, hfwq_ring, hfwq_hold and hdlc_frame_wire_queue_defines.svh.
//
// Usage. A request is taken at a rising edge where start is high and busy is low;
// cmd selects send, end of frame, receive, peek, discontinue or raw resend, and
// data_byte with the two mark inputs carry the payload. Every request gives one
// result: done is high for exactly one cycle and the result ports are valid in
// that cycle. Commands that return nothing show all result fields at zero.
//
// Timing. Send, resend, receive, peek and unknown codes go from the request to the
// run state, which does the work on the ring, and done rises in the cycle after
// that, which is also a cycle in which the next request can be taken. End of frame
// writes one held byte per cycle through the single ring write port in the flush
// state. Discontinue reads one ring entry per cycle through the registered read
// port until it drops a frame end or finds the ring empty. The ring read is
// addressed with the next read pointer, so the registered port is ready in time.
//
// Reset clears the pointers, the hold count and the sequencer; no clearing pass
// runs, because only entries that were written since reset can ever be read.
// The receiver cannot stall: results are presented once and must be taken.
`include "hdlc_frame_wire_queue_defines.svh"

module hdlc_frame_wire_queue
    import hfwq_pkg::*;
#(
    parameter int RING_DEPTH = 256,
    parameter int HOLD_DEPTH = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic        in_address_mark,
    input  logic        in_end_mark,
    output logic        done,
    output logic [7:0]  out_byte,
    output logic        out_address_mark,
    output logic        out_end_mark,
    output logic        out_data_mark,
    output logic        ring_empty,
    output logic        no_frame_end
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    hfwq_state_t       state_reg, state_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [IDX_W-1:0]  flush_idx_reg, flush_idx_next;

    // Request captured at acceptance.
    logic [2:0]        cmd_reg, cmd_next;
    logic [7:0]        byte_reg, byte_next;
    logic              amark_reg, amark_next;
    logic              emark_reg, emark_next;

    // Result register.
    logic              done_reg, done_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_amark_reg, out_amark_next;
    logic              out_emark_reg, out_emark_next;
    logic              out_dmark_reg, out_dmark_next;
    logic              empty_reg, empty_next;
    logic              nfe_reg, nfe_next;

    logic              wr_en;
    hfwq_entry_t       wr_entry;
    hfwq_entry_t       ring_rd;
    hfwq_hold_ctrl_t   hold_ctrl;
    logic [CNT_W-1:0]  hold_count;
    logic              hold_full;
    hfwq_entry_t       hold_head;
    hfwq_entry_t       hold_rd;
    logic              accept;
    logic              ring_is_empty;
    logic              flush_last;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    hfwq_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wp_reg),
        .wr_entry (wr_entry),
        .rd_addr  (rp_next),
        .rd_entry (ring_rd)
    );

    hfwq_hold #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (hold_ctrl),
        .push_byte (byte_reg),
        .rd_idx    (flush_idx_reg),
        .count     (hold_count),
        .full      (hold_full),
        .head      (hold_head),
        .rd_entry  (hold_rd)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign ring_is_empty = (rp_reg == wp_reg);
    assign flush_last    = ((CNT_W'(flush_idx_reg) + CNT_W'(1)) == hold_count);

    // The ring is read at rp_next every cycle. Writes happen only in the run and
    // flush states, both of which end in idle, and idle reads the head again, so in
    // the run and discard states ring_rd always holds the entry at rp_reg.
    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        flush_idx_next = flush_idx_reg;
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        amark_next     = amark_reg;
        emark_next     = emark_reg;
        wr_en          = 1'b0;
        wr_entry       = hold_head;
        hold_ctrl      = '0;
        done_next      = 1'b0;
        out_byte_next  = '0;
        out_amark_next = 1'b0;
        out_emark_next = 1'b0;
        out_dmark_next = 1'b0;
        empty_next     = 1'b0;
        nfe_next       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = cmd;
                    byte_next      = data_byte;
                    amark_next     = in_address_mark;
                    emark_next     = in_end_mark;
                    flush_idx_next = '0;
                    if (cmd == CMD_DISCARD)
                    begin
                        state_next = ST_DISC;
                    end
                    else if (cmd == CMD_EOF && hold_count != '0)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    CMD_SEND:
                    begin
                        hold_ctrl.push = 1'b1;
                        if (hold_full)
                        begin
                            wr_en    = 1'b1;
                            wr_entry = hold_head;
                            wp_next  = advance(wp_reg);
                        end
                    end
                    CMD_RESEND:
                    begin
                        wr_en             = 1'b1;
                        wr_entry.data      = byte_reg;
                        wr_entry.addr_mark = amark_reg;
                        wr_entry.end_mark  = emark_reg;
                        wp_next           = advance(wp_reg);
                    end
                    CMD_RECEIVE, CMD_PEEK:
                    begin
                        if (ring_is_empty)
                        begin
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            out_byte_next  = ring_rd.data;
                            out_amark_next = ring_rd.addr_mark;
                            out_emark_next = ring_rd.end_mark;
                            if (cmd_reg == CMD_RECEIVE)
                            begin
                                rp_next = advance(rp_reg);
                            end
                            else
                            begin
                                out_dmark_next = !ring_rd.addr_mark && !ring_rd.end_mark;
                            end
                        end
                    end
                    default:
                    begin
                        // End of frame with nothing held and unused codes do nothing.
                    end
                endcase
            end

            ST_FLUSH:
            begin
                // Held bytes go out oldest first; the newest gets the end mark.
                wr_en             = 1'b1;
                wr_entry          = hold_rd;
                wr_entry.end_mark = hold_rd.end_mark | flush_last;
                wp_next           = advance(wp_reg);
                flush_idx_next    = flush_idx_reg + IDX_W'(1);
                if (flush_last)
                begin
                    hold_ctrl.clear = 1'b1;
                    state_next      = ST_IDLE;
                    done_next       = 1'b1;
                end
            end

            ST_DISC:
            begin
                if (ring_is_empty)
                begin
                    nfe_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rp_next = advance(rp_reg);
                    if (ring_rd.end_mark)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rp_reg    <= '0;
            wp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flush_idx_reg <= flush_idx_next;
        cmd_reg       <= cmd_next;
        byte_reg      <= byte_next;
        amark_reg     <= amark_next;
        emark_reg     <= emark_next;
        out_byte_reg  <= out_byte_next;
        out_amark_reg <= out_amark_next;
        out_emark_reg <= out_emark_next;
        out_dmark_reg <= out_dmark_next;
        empty_reg     <= empty_next;
        nfe_reg       <= nfe_next;
    end

    assign done             = done_reg;
    assign out_byte         = out_byte_reg;
    assign out_address_mark = out_amark_reg;
    assign out_end_mark     = out_emark_reg;
    assign out_data_mark    = out_dmark_reg;
    assign ring_empty       = empty_reg;
    assign no_frame_end     = nfe_reg;

    // done never rises in the cycle after a request is accepted; every request first passes through a work state.
    `HFWQ_ASSERT_NEXT(a_no_done_after_accept, clk, rst_n, accept, !done_reg, "done right after accept")
    // The empty report and the missing frame end belong to different commands.
    `HFWQ_ASSERT_NEVER(a_flags_exclusive, clk, rst_n, empty_reg && nfe_reg, "conflicting result flags")
    // The hold buffer never keeps more than its depth.
    `HFWQ_ASSERT_NEVER(a_hold_bound, clk, rst_n, hold_count > CNT_W'(HOLD_DEPTH), "hold overflow")
    // A flush only runs while bytes are held.
    `HFWQ_ASSERT_NEVER(a_flush_nonempty, clk, rst_n, (state_reg == ST_FLUSH) && (hold_count == '0), "flush with empty hold")

endmodule

@@ sim/hdlc_frame_wire_queue_tb.sv @@
// Self-checking testbench for the frame wire queue: a directed table followed by random traffic.
// Depends on hfwq_pkg and the hdlc_frame_wire_queue RTL; every result is checked against the
// expected value of a typed directed row or else a cycle-free software copy of the queue.
module hdlc_frame_wire_queue_tb;
    import hfwq_pkg::*;

    localparam int RING_DEPTH = 256;
    localparam int HOLD_DEPTH = 3;
    localparam int TOTAL_REQUESTS = 1450;
    // Neither a discontinue that walks the whole ring nor a random pause of the sender
    // comes near this limit, so reaching it can only mean the block has hung.
    localparam int QUIET_LIMIT = 4000;

    // The two command codes that the block must treat as no-ops.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] value;
        logic       addr_mark;
        logic       end_mark;
        logic       data_mark;
        logic       empty;
        logic       no_end;
    } queue_result_t;

    // One row of the directed table. Where typed is set, want is the result to expect;
    // otherwise the software copy of the queue supplies it.
    typedef struct packed {
        logic [2:0]    op;
        logic [7:0]    data;
        logic          am;
        logic          em;
        logic          typed;
        queue_result_t want;
    } stim_row_t;

    localparam queue_result_t RES_NONE = '0;
    localparam queue_result_t RES_EMPTY = '{value: 8'h00, addr_mark: 1'b0, end_mark: 1'b0,
                                            data_mark: 1'b0, empty: 1'b1, no_end: 1'b0};
    localparam queue_result_t RES_NO_END = '{value: 8'h00, addr_mark: 1'b0, end_mark: 1'b0,
                                             data_mark: 1'b0, empty: 1'b0, no_end: 1'b1};

    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Reads, discontinue and end of frame on an empty queue straight after reset.
        '{CMD_RECEIVE, 8'h00, 1'b0, 1'b0, 1'b1, RES_EMPTY},
        '{CMD_PEEK,    8'h00, 1'b0, 1'b0, 1'b1, RES_EMPTY},
        '{CMD_DISCARD, 8'h00, 1'b0, 1'b0, 1'b1, RES_NO_END},
        '{CMD_EOF,     8'h00, 1'b0, 1'b0, 1'b1, RES_NONE},
        // Four sends: the fourth overflows the hold-back buffer into the ring.
        '{CMD_SEND,    8'h00, 1'b0, 1'b0, 1'b1, RES_NONE},
        '{CMD_SEND,    8'hFF, 1'b1, 1'b1, 1'b1, RES_NONE},
        '{CMD_SEND,    8'hA5, 1'b0, 1'b0, 1'b1, RES_NONE},
        '{CMD_SEND,    8'h5A, 1'b0, 1'b0, 1'b1, RES_NONE},
        '{CMD_EOF,     8'h00, 1'b0, 1'b0, 1'b1, RES_NONE},
        '{CMD_PEEK,    8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        '{CMD_RECEIVE, 8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        '{CMD_PEEK,    8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        // Raw entries with both marks and with none.
        '{CMD_RESEND,  8'hFF, 1'b1, 1'b1, 1'b1, RES_NONE},
        '{CMD_RESEND,  8'h00, 1'b0, 1'b0, 1'b1, RES_NONE},
        '{CMD_DISCARD, 8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        '{CMD_RECEIVE, 8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        '{CMD_RECEIVE, 8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        '{CMD_RECEIVE, 8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        // Unused codes with every payload bit set change nothing.
        '{CMD_SPARE_A, 8'hFF, 1'b1, 1'b1, 1'b1, RES_NONE},
        '{CMD_SPARE_B, 8'hFF, 1'b1, 1'b1, 1'b1, RES_NONE},
        // A one-byte frame carries both marks; two discontinues drain it and then miss.
        '{CMD_SEND,    8'h3C, 1'b0, 1'b0, 1'b1, RES_NONE},
        '{CMD_EOF,     8'h00, 1'b0, 1'b0, 1'b1, RES_NONE},
        '{CMD_PEEK,    8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        '{CMD_DISCARD, 8'h00, 1'b0, 1'b0, 1'b0, RES_NONE},
        '{CMD_DISCARD, 8'h00, 1'b0, 1'b0, 1'b1, RES_NO_END}
    };

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       in_address_mark;
    logic       in_end_mark;
    logic       done;
    logic [7:0] out_byte;
    logic       out_address_mark;
    logic       out_end_mark;
    logic       out_data_mark;
    logic       ring_empty;
    logic       no_frame_end;

    // Side information that travels with the request on the bus.
    logic          req_typed;
    queue_result_t req_want;

    // Software copy of the queue, advanced once per accepted request.
    hfwq_entry_t ring_copy [RING_DEPTH];
    hfwq_entry_t hold_copy [HOLD_DEPTH];
    int          hold_fill;
    int          head_ptr;
    int          tail_ptr;

    queue_result_t results_due [$];
    int            requests_taken;
    int            requests_issued;
    int            mismatches;
    int            quiet_cycles;
    int            idle_pct;

    hdlc_frame_wire_queue #(
        .RING_DEPTH(RING_DEPTH),
        .HOLD_DEPTH(HOLD_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .data_byte(data_byte),
        .in_address_mark(in_address_mark),
        .in_end_mark(in_end_mark),
        .done(done),
        .out_byte(out_byte),
        .out_address_mark(out_address_mark),
        .out_end_mark(out_end_mark),
        .out_data_mark(out_data_mark),
        .ring_empty(ring_empty),
        .no_frame_end(no_frame_end)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Ring writes never check for room: one that brings the tail onto the head makes the ring look empty.
    function automatic void ring_write(input hfwq_entry_t e);
        ring_copy[tail_ptr] = e;
        tail_ptr = (tail_ptr + 1) % RING_DEPTH;
    endfunction

    // Applies one request to the software copy and returns the result it must produce.
    function automatic queue_result_t predict_wire_result(input logic [2:0] op,
                                                          input logic [7:0] data,
                                                          input logic am,
                                                          input logic em);
        queue_result_t r;
        hfwq_entry_t   e;
        bit            found;
        r = RES_NONE;
        e = '0;
        found = 1'b0;
        case (op)
            CMD_SEND:
            begin
                e.data = data;
                // Only the first byte after an empty hold buffer opens a frame.
                e.addr_mark = (hold_fill == 0);
                if (hold_fill < HOLD_DEPTH)
                begin
                    hold_copy[hold_fill] = e;
                    hold_fill++;
                end
                else
                begin
                    ring_write(hold_copy[0]);
                    for (int i = 0; i + 1 < HOLD_DEPTH; i++)
                        hold_copy[i] = hold_copy[i + 1];
                    hold_copy[HOLD_DEPTH - 1] = e;
                end
            end
            CMD_EOF:
            begin
                if (hold_fill > 0)
                begin
                    hold_copy[hold_fill - 1].end_mark = 1'b1;
                    for (int i = 0; i < hold_fill; i++)
                        ring_write(hold_copy[i]);
                    hold_fill = 0;
                end
            end
            CMD_RECEIVE, CMD_PEEK:
            begin
                if (head_ptr == tail_ptr)
                    r.empty = 1'b1;
                else
                begin
                    e = ring_copy[head_ptr];
                    r.value = e.data;
                    r.addr_mark = e.addr_mark;
                    r.end_mark = e.end_mark;
                    if (op == CMD_RECEIVE)
                        head_ptr = (head_ptr + 1) % RING_DEPTH;
                    else
                        r.data_mark = !e.addr_mark && !e.end_mark;
                end
            end
            CMD_DISCARD:
            begin
                // Drop entries up to and including the next end of frame.
                while (head_ptr != tail_ptr && !found)
                begin
                    found = ring_copy[head_ptr].end_mark;
                    head_ptr = (head_ptr + 1) % RING_DEPTH;
                end
                r.no_end = !found;
            end
            CMD_RESEND:
            begin
                e.data = data;
                e.addr_mark = am;
                e.end_mark = em;
                ring_write(e);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Monitor. Results are compared before the request of the same edge is recorded,
    // because a result always belongs to an earlier request.
    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{value: out_byte, addr_mark: out_address_mark,
                        end_mark: out_end_mark, data_mark: out_data_mark,
                        empty: ring_empty, no_end: no_frame_end};
                if (results_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %0h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("out_byte", want.value, got.value);
                    check_field("out_address_mark", 8'(want.addr_mark), 8'(got.addr_mark));
                    check_field("out_end_mark", 8'(want.end_mark), 8'(got.end_mark));
                    check_field("out_data_mark", 8'(want.data_mark), 8'(got.data_mark));
                    check_field("ring_empty", 8'(want.empty), 8'(got.empty));
                    check_field("no_frame_end", 8'(want.no_end), 8'(got.no_end));
                end
            end
            if (start && !busy)
            begin
                // The copy always advances; a typed row only overrides what is expected.
                want = predict_wire_result(cmd, data_byte, in_address_mark, in_end_mark);
                results_due.push_back(req_typed ? req_want : want);
                requests_taken++;
            end
        end
    end

    // Watchdog: ends the run when neither a request nor a result has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drives one request from a falling edge and returns at the falling edge after it
    // was taken. The sender then pauses at random so that gaps land on every phase.
    task automatic issue_request(input logic [2:0] op, input logic [7:0] data,
                                 input logic am, input logic em,
                                 input logic typed = 1'b0,
                                 input queue_result_t want = '0);
        int seen;
        seen = requests_taken;
        start = 1'b1;
        cmd = op;
        data_byte = data;
        in_address_mark = am;
        in_end_mark = em;
        req_typed = typed;
        req_want = want;
        requests_issued++;
        @(negedge clk);
        while (requests_taken == seen)
            @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            // Payload is junk while start is low.
            start = 1'b0;
            cmd = 3'($urandom);
            data_byte = 8'($urandom);
            in_address_mark = 1'($urandom);
            in_end_mark = 1'($urandom);
            repeat ($urandom_range(1, 5))
                @(negedge clk);
        end
    endtask

    initial
    begin
        int  pick;
        int  n;
        bit  overrun_done;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_SEND;
        data_byte = 8'h00;
        in_address_mark = 1'b0;
        in_end_mark = 1'b0;
        req_typed = 1'b0;
        req_want = RES_NONE;
        for (int i = 0; i < RING_DEPTH; i++)
            ring_copy[i] = '0;
        for (int i = 0; i < HOLD_DEPTH; i++)
            hold_copy[i] = '0;
        hold_fill = 0;
        head_ptr = 0;
        tail_ptr = 0;
        requests_taken = 0;
        requests_issued = 0;
        mismatches = 0;
        quiet_cycles = 0;
        idle_pct = 9;
        overrun_done = 1'b0;

        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_request(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].am, DIRECTED[i].em,
                          DIRECTED[i].typed, DIRECTED[i].want);

        // Random traffic: frames, reads, discontinues, raw entries and noise. Apart from the one overrun,
        // when the ring holds more than 48 entries only reads are issued, so the ring does not fill up.
        while (requests_issued < TOTAL_REQUESTS)
        begin
            idle_pct = (requests_issued >= 500 && requests_issued < 800) ? 0 : 9;
            pick = $urandom_range(99);
            if (!overrun_done && requests_issued >= 900)
            begin
                // Fill the ring for one full turn plus up to two entries without reading: the write pointer
                // catches the read pointer and the stored entries drop out of sight.
                overrun_done = 1'b1;
                n = RING_DEPTH + $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                    issue_request(CMD_RESEND, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            else if (((tail_ptr - head_ptr + RING_DEPTH) % RING_DEPTH) > 48 || pick < 25)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    issue_request(($urandom_range(9) < 7) ? CMD_RECEIVE : CMD_PEEK,
                                  8'($urandom), 1'($urandom), 1'($urandom));
            end
            else if (pick < 65)
            begin
                // A well-formed frame; now and then a long one that streams through the
                // hold-back buffer, and now and then one left open so the next continues it.
                n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    issue_request(CMD_SEND, 8'($urandom), 1'($urandom), 1'($urandom));
                if ($urandom_range(9) != 0)
                    issue_request(CMD_EOF, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            else if (pick < 75)
            begin
                if ($urandom_range(1) == 1)
                    issue_request(CMD_PEEK, 8'($urandom), 1'($urandom), 1'($urandom));
                issue_request(CMD_DISCARD, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    issue_request(CMD_RESEND, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            else if (pick < 92)
            begin
                // Noise: unused codes and end of frame whether or not anything is held.
                case ($urandom_range(2))
                    0: issue_request(CMD_SPARE_A, 8'($urandom), 1'($urandom), 1'($urandom));
                    1: issue_request(CMD_SPARE_B, 8'($urandom), 1'($urandom), 1'($urandom));
                    default: issue_request(CMD_EOF, 8'($urandom), 1'($urandom), 1'($urandom));
                endcase
            end
            else
            begin
                // Broken frame: a raw entry or a discontinue lands in the middle of a
                // frame, and the closing end of frame is doubled.
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    issue_request(CMD_SEND, 8'($urandom), 1'($urandom), 1'($urandom));
                if ($urandom_range(1) == 1)
                    issue_request(CMD_RESEND, 8'($urandom), 1'($urandom), 1'($urandom));
                else
                    issue_request(CMD_DISCARD, 8'($urandom), 1'($urandom), 1'($urandom));
                issue_request(CMD_EOF, 8'($urandom), 1'($urandom), 1'($urandom));
                issue_request(CMD_EOF, 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end

        start = 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        // Keep the clock running to catch a stray result after the last expected one.
        repeat (10)
            @(negedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
